FILE: rtl/core/aat_pkg.sv
// ----------------------------------------------------------------------------
// aat_pkg
// Shared types and constants for the bounding box affine transform block.
// ----------------------------------------------------------------------------
`default_nettype none

package aat_pkg;

    localparam int NUM_AXES        = 3;
    localparam int NUM_STAGES      = 4;
    localparam int CFG_DATA_WIDTH  = 48;
    localparam int CFG_INDEX_WIDTH = 3;
    localparam int OFFSET_WIDTH    = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_X    = 3'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Y    = 3'd1;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_ROW_Z    = 3'd2;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_X = 3'd3;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Y = 3'd4;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_OFFSET_Z = 3'd5;

    typedef struct packed {
        logic [NUM_STAGES-1:0] load;
    } aat_stage_ctl_t;

endpackage

`default_nettype wire

FILE: rtl/core/aat_pipe_ctrl.sv
// ----------------------------------------------------------------------------
// aat_pipe_ctrl
// Valid bits and per-stage load enables for the transform pipeline.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_pipe_ctrl
    import aat_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    output logic           out_valid,
    input  logic           out_ready,
    output aat_stage_ctl_t ctl
);

    logic [NUM_STAGES-1:0] valid_reg;
    logic [NUM_STAGES-1:0] valid_next;
    logic [NUM_STAGES-1:0] rdy;

    always_comb
    begin
        rdy[NUM_STAGES-1] = !valid_reg[NUM_STAGES-1] || out_ready;
        for (int i = NUM_STAGES - 2; i >= 0; i--)
        begin
            rdy[i] = !valid_reg[i] || rdy[i+1];
        end
    end

    always_comb
    begin
        ctl.load[0]   = in_valid && rdy[0];
        valid_next[0] = rdy[0] ? in_valid : valid_reg[0];
        for (int i = 1; i < NUM_STAGES; i++)
        begin
            ctl.load[i]   = valid_reg[i-1] && rdy[i];
            valid_next[i] = rdy[i] ? valid_reg[i-1] : valid_reg[i];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = valid_reg[NUM_STAGES-1];

    logic in_fire;
    logic out_fire;
    assign in_fire  = in_valid && in_ready;
    assign out_fire = out_valid && out_ready;

    // requests in flight: accepted minus delivered
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> $countones(valid_reg) ==
            $countones($past(valid_reg)) + $past(in_fire) - $past(out_fire))
        else $error("pipeline request count mismatch");

    a_backpressure: assert property (@(posedge clk) disable iff (!rst_n)
        !in_ready |-> (&valid_reg) && !out_ready)
        else $error("input stalled with room in pipeline");

    a_full_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (&valid_reg) && !out_ready |=> (&valid_reg))
        else $error("stalled full pipeline lost a request");

endmodule

`default_nettype wire

FILE: rtl/core/aat_axis.sv
// ----------------------------------------------------------------------------
// aat_axis
// One output axis: products, per-term min/max, sums, shift, offset, saturate.
// ----------------------------------------------------------------------------
`default_nettype none

module aat_axis
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16,
    parameter int ROW_W       = 48
)
(
    input  logic                                 clk,
    input  aat_stage_ctl_t                       ctl,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo,
    input  logic [NUM_AXES-1:0][COORD_WIDTH-1:0] hi,
    input  logic [ROW_W-1:0]                     row,
    input  logic signed [OFFSET_WIDTH-1:0]       offset,
    output logic [COORD_WIDTH-1:0]               new_lo,
    output logic [COORD_WIDTH-1:0]               new_hi
);

    localparam int CF    = COEF_WIDTH - 4;
    localparam int PW    = COORD_WIDTH + COEF_WIDTH;
    localparam int SW    = PW + 2;
    localparam int TW    = SW - CF;
    localparam int RW    = ((TW > OFFSET_WIDTH) ? TW : OFFSET_WIDTH) + 1;
    localparam int EXT_W = NUM_AXES * COEF_WIDTH;

    localparam logic signed [RW-1:0] SAT_HI =
        RW'(signed'({1'b0, {(COORD_WIDTH-1){1'b1}}}));
    localparam logic signed [RW-1:0] SAT_LO = ~SAT_HI;

    logic [EXT_W-1:0]             row_ext;
    logic signed [COEF_WIDTH-1:0] coef      [NUM_AXES];
    logic signed [PW-1:0]         plo_next  [NUM_AXES];
    logic signed [PW-1:0]         phi_next  [NUM_AXES];
    logic signed [PW-1:0]         plo_reg   [NUM_AXES];
    logic signed [PW-1:0]         phi_reg   [NUM_AXES];
    logic signed [PW-1:0]         mn_next   [NUM_AXES];
    logic signed [PW-1:0]         mx_next   [NUM_AXES];
    logic signed [PW-1:0]         mn_reg    [NUM_AXES];
    logic signed [PW-1:0]         mx_reg    [NUM_AXES];
    logic signed [SW-1:0]         smin_next;
    logic signed [SW-1:0]         smax_next;
    logic signed [SW-1:0]         smin_reg;
    logic signed [SW-1:0]         smax_reg;
    logic [COORD_WIDTH-1:0]       new_lo_next;
    logic [COORD_WIDTH-1:0]       new_hi_next;
    logic [COORD_WIDTH-1:0]       new_lo_reg;
    logic [COORD_WIDTH-1:0]       new_hi_reg;

    // floor shift to Q16.16, add offset, clamp to coordinate range
    function automatic logic [COORD_WIDTH-1:0] finish(
        input logic signed [SW-1:0]           s,
        input logic signed [OFFSET_WIDTH-1:0] off
    );
        logic signed [RW-1:0] r;
        r = RW'(s >>> CF) + RW'(off);
        if (r > SAT_HI)
        begin
            r = SAT_HI;
        end
        else if (r < SAT_LO)
        begin
            r = SAT_LO;
        end
        return COORD_WIDTH'(r);
    endfunction

    assign row_ext = EXT_W'(row);

    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            coef[k]     = signed'(row_ext[k*COEF_WIDTH +: COEF_WIDTH]);
            plo_next[k] = PW'(signed'(lo[k])) * PW'(coef[k]);
            phi_next[k] = PW'(signed'(hi[k])) * PW'(coef[k]);
        end
    end

    // final value is monotone in the sum, so per-term extremes suffice
    always_comb
    begin
        for (int k = 0; k < NUM_AXES; k++)
        begin
            mn_next[k] = (plo_reg[k] < phi_reg[k]) ? plo_reg[k] : phi_reg[k];
            mx_next[k] = (plo_reg[k] < phi_reg[k]) ? phi_reg[k] : plo_reg[k];
        end
    end

    assign smin_next = SW'(mn_reg[0]) + SW'(mn_reg[1]) + SW'(mn_reg[2]);
    assign smax_next = SW'(mx_reg[0]) + SW'(mx_reg[1]) + SW'(mx_reg[2]);

    assign new_lo_next = finish(smin_reg, offset);
    assign new_hi_next = finish(smax_reg, offset);

    always_ff @(posedge clk)
    begin
        if (ctl.load[0])
        begin
            plo_reg <= plo_next;
            phi_reg <= phi_next;
        end
        if (ctl.load[1])
        begin
            mn_reg <= mn_next;
            mx_reg <= mx_next;
        end
        if (ctl.load[2])
        begin
            smin_reg <= smin_next;
            smax_reg <= smax_next;
        end
        if (ctl.load[3])
        begin
            new_lo_reg <= new_lo_next;
            new_hi_reg <= new_hi_next;
        end
    end

    assign new_lo = new_lo_reg;
    assign new_hi = new_hi_reg;

endmodule

`default_nettype wire

FILE: rtl/core/aabb_affine_transform_top.sv
// ----------------------------------------------------------------------------
// aabb_affine_transform_top
// Maps an axis-aligned box through an affine transform and returns the
// bounding box of the mapped corners.
//
//   channel   signals                                  direction
//   input     in_valid/in_ready, lo_*, hi_*            into block
//   output    out_valid/out_ready, new_lo_*, new_hi_*  out of block
//   config    cfg_wr_en, cfg_index, cfg_data           into block
//
// One request per cycle unless stalled; multiply, min/max, sum, saturate.
// Reset clears the stage valid bits and loads the identity transform.
// A stall at the output holds the last stage; earlier stages keep filling
// bubbles, and in_ready drops only when all four stages hold requests.
// ----------------------------------------------------------------------------
`default_nettype none

module aabb_affine_transform_top
    import aat_pkg::*;
#(
    parameter int COORD_WIDTH = 32,
    parameter int COEF_WIDTH  = 16
)
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic signed [COORD_WIDTH-1:0]     lo_x,
    input  logic signed [COORD_WIDTH-1:0]     lo_y,
    input  logic signed [COORD_WIDTH-1:0]     lo_z,
    input  logic signed [COORD_WIDTH-1:0]     hi_x,
    input  logic signed [COORD_WIDTH-1:0]     hi_y,
    input  logic signed [COORD_WIDTH-1:0]     hi_z,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [COORD_WIDTH-1:0]     new_lo_x,
    output logic signed [COORD_WIDTH-1:0]     new_lo_y,
    output logic signed [COORD_WIDTH-1:0]     new_lo_z,
    output logic signed [COORD_WIDTH-1:0]     new_hi_x,
    output logic signed [COORD_WIDTH-1:0]     new_hi_y,
    output logic signed [COORD_WIDTH-1:0]     new_hi_z,
    input  logic                              cfg_wr_en,
    input  logic [CFG_INDEX_WIDTH-1:0]        cfg_index,
    input  logic [CFG_DATA_WIDTH-1:0]         cfg_data
);

    localparam int EXT_W = NUM_AXES * COEF_WIDTH;
    localparam int ROW_W = (EXT_W < CFG_DATA_WIDTH) ? CFG_DATA_WIDTH :
                           ((EXT_W > 64) ? 64 : EXT_W);

    localparam logic [63:0]      COEF_ONE  = 64'd1 << (COEF_WIDTH - 4);
    localparam logic [ROW_W-1:0] ROW_X_RST = ROW_W'(COEF_ONE);
    localparam logic [ROW_W-1:0] ROW_Y_RST = ROW_W'(COEF_ONE << COEF_WIDTH);
    localparam logic [ROW_W-1:0] ROW_Z_RST = ROW_W'(COEF_ONE << (2 * COEF_WIDTH));

    logic [ROW_W-1:0]               row_reg [NUM_AXES];
    logic signed [OFFSET_WIDTH-1:0] off_reg [NUM_AXES];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg[0] <= ROW_X_RST;
            row_reg[1] <= ROW_Y_RST;
            row_reg[2] <= ROW_Z_RST;
            off_reg[0] <= '0;
            off_reg[1] <= '0;
            off_reg[2] <= '0;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_ROW_X:    row_reg[0] <= ROW_W'(cfg_data);
                REG_ROW_Y:    row_reg[1] <= ROW_W'(cfg_data);
                REG_ROW_Z:    row_reg[2] <= ROW_W'(cfg_data);
                REG_OFFSET_X: off_reg[0] <= OFFSET_WIDTH'(cfg_data);
                REG_OFFSET_Y: off_reg[1] <= OFFSET_WIDTH'(cfg_data);
                REG_OFFSET_Z: off_reg[2] <= OFFSET_WIDTH'(cfg_data);
                default:      ;
            endcase
        end
    end

    aat_stage_ctl_t                       ctl;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] lo_vec;
    logic [NUM_AXES-1:0][COORD_WIDTH-1:0] hi_vec;
    logic [COORD_WIDTH-1:0]               res_lo [NUM_AXES];
    logic [COORD_WIDTH-1:0]               res_hi [NUM_AXES];

    assign lo_vec = {lo_z, lo_y, lo_x};
    assign hi_vec = {hi_z, hi_y, hi_x};

    aat_pipe_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .ctl       (ctl)
    );

    for (genvar a = 0; a < NUM_AXES; a++)
    begin : g_axis
        aat_axis #(
            .COORD_WIDTH (COORD_WIDTH),
            .COEF_WIDTH  (COEF_WIDTH),
            .ROW_W       (ROW_W)
        ) u_axis (
            .clk    (clk),
            .ctl    (ctl),
            .lo     (lo_vec),
            .hi     (hi_vec),
            .row    (row_reg[a]),
            .offset (off_reg[a]),
            .new_lo (res_lo[a]),
            .new_hi (res_hi[a])
        );
    end

    assign new_lo_x = res_lo[0];
    assign new_lo_y = res_lo[1];
    assign new_lo_z = res_lo[2];
    assign new_hi_x = res_hi[0];
    assign new_hi_y = res_hi[1];
    assign new_hi_z = res_hi[2];

endmodule

`default_nettype wire
